@@ hw/rtl/evalue_filter_top_k_per_query_defines.svh @@
// Assertion macros for the evalue_filter_top_k_per_query checker.
// No dependencies; the asserting files include this header.
`ifndef EVALUE_FILTER_TOP_K_PER_QUERY_DEFINES_SVH
`define EVALUE_FILTER_TOP_K_PER_QUERY_DEFINES_SVH

// Clocked assertion, disabled while reset is held.
`define EFK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define EFK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/efk_pkg.sv @@
// Types and codes shared by the per-query top-k hit screen.
// No dependencies.
`default_nettype none

package efk_pkg;

    // one stored list entry
    typedef struct packed {
        logic [31:0]        tag;
        logic [15:0]        score;
        logic signed [15:0] evalue;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // result status codes
    typedef enum logic [2:0] {
        STAT_KEPT    = 3'd0,
        STAT_LOW     = 3'd1,
        STAT_HIGH    = 3'd2,
        STAT_RANKED  = 3'd3,
        STAT_DRAINED = 3'd4
    } t_status;

    // input item kinds
    localparam logic KIND_HIT   = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MIN_RAW   = 2'd0,
        REG_MAX_EV    = 2'd1,
        REG_DB_SIZE   = 2'd2,
        REG_KEEP_LIM  = 2'd3
    } t_reg_idx;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DECIDE,
        S_WB,
        S_DISP,
        S_DRAIN
    } t_state;

    // commands to the row of list cells
    typedef struct packed {
        logic load;
        logic insert;
        logic shift;
    } t_cell_ctl;

    // one result item
    typedef struct packed {
        logic [5:0]         out_query;
        logic [31:0]        out_tag;
        logic [15:0]        out_score;
        logic signed [15:0] out_evalue_log2;
        t_status            status;
        logic               entry_valid;
        logic               last;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/efk_if.sv @@
// Valid/ready channels of the per-query top-k hit screen: hit items in,
// result items out. No dependencies.
`default_nettype none

interface efk_hit_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [5:0]  query_index;
    logic [31:0] hit_tag;
    logic [15:0] raw_score;
    logic [15:0] bit_score;
    logic [12:0] query_len_log2;

    modport source (output valid, kind, query_index, hit_tag, raw_score, bit_score,
                    query_len_log2, input ready);
    modport sink   (input valid, kind, query_index, hit_tag, raw_score, bit_score,
                    query_len_log2, output ready);
endinterface

interface efk_res_if;
    logic               valid;
    logic               ready;
    logic [5:0]         out_query;
    logic [31:0]        out_tag;
    logic [15:0]        out_score;
    logic signed [15:0] out_evalue_log2;
    logic [2:0]         status;
    logic               entry_valid;
    logic               last;

    modport source (output valid, out_query, out_tag, out_score, out_evalue_log2, status,
                    entry_valid, last, input ready);
    modport sink   (input valid, out_query, out_tag, out_score, out_evalue_log2, status,
                    entry_valid, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/efk_cell.sv @@
// One slot of a query's ranked list; cells form a chain that inserts,
// loads a stored row and shifts out toward slot 0. Uses efk_pkg.
`default_nettype none

module efk_cell
    import efk_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  wire logic          i_clk,
    input  wire t_cell_ctl     i_ctl,
    input  wire logic [CW-1:0] i_n,
    input  wire t_entry        i_new,
    input  wire t_entry        i_load,
    input  wire t_entry        i_prev,
    input  wire logic          i_prev_flag,
    input  wire t_entry        i_next,
    output t_entry             o_entry,
    output logic               o_flag
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_valid;
    logic   w_before;

    // new item ranks ahead of this slot, or the slot is past the list end
    assign w_valid  = (CW'(IDX) < i_n);
    assign w_before = (i_new.evalue < r_entry.evalue) ||
                      ((i_new.evalue == r_entry.evalue) && (i_new.score > r_entry.score));
    assign o_flag   = !w_valid || w_before;
    assign o_entry  = r_entry;

    // pick load, insert, shift-from-left or shift-toward-output
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load) begin
            n_entry = i_load;
        end else if (i_ctl.insert) begin
            if (i_prev_flag) begin
                n_entry = i_prev;
            end else if (o_flag) begin
                n_entry = i_new;
            end
        end else if (i_ctl.shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

@@ hw/rtl/evalue_filter_top_k_per_query.sv @@
// Per-query top-k screen for alignment hits. A kept hit goes through these
// steps: the row read of the query's list memory at the accepting edge,
// loading the list into the cell chain, ranking and emitting, and writing the
// row back. A hit dropped for low score, high E-value or rank skips the write
// back; a hit that displaces an entry adds a result for the displaced entry.
// A drain emits one result per entry, or one result for an empty list. Input
// ready is high only while no item is in work; result items wait in an output
// register, and the sequencer waits while the receiver holds off.
// Uses efk_pkg, efk_if and efk_cell.
`default_nettype none

module evalue_filter_top_k_per_query
    import efk_pkg::*;
#(
    parameter int QUERIES = 64,
    parameter int KEEP    = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    efk_hit_if.sink     i_hit,
    efk_res_if.source   o_res,
    input  wire logic   psel,
    input  wire logic   penable,
    input  wire logic   pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QW    = (QUERIES > 1) ? $clog2(QUERIES) : 1;
    localparam int CW    = $clog2(KEEP + 1);
    localparam int IW    = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int ROW_W = CW + KEEP * ENTRY_W;

    // wrap table for query indexes, built at elaboration
    function automatic logic [64*QW-1:0] build_qmod();
        logic [64*QW-1:0] tbl;
        tbl = '0;
        for (int k = 0; k < 64; k++) begin
            tbl[k*QW +: QW] = QW'(k % QUERIES);
        end
        return tbl;
    endfunction

    localparam logic [64*QW-1:0] QMOD_TBL = build_qmod();

    // held item
    typedef struct packed {
        logic        kind;
        logic [5:0]  query_index;
        logic [31:0] hit_tag;
        logic [15:0] raw_score;
        logic [15:0] bit_score;
        logic [12:0] query_len_log2;
    } t_item;

    t_state  r_state, n_state;
    t_item   r_item;
    logic [QW-1:0] r_q;
    logic [CW-1:0] r_n;
    logic signed [15:0] r_ev;
    logic    r_ev_high;
    t_entry  r_disp;
    logic    r_disp_pend;
    logic    r_ovalid;
    t_result r_res;

    logic [15:0] r_min_raw;
    logic signed [15:0] r_max_ev;
    logic [13:0] r_db;
    logic [4:0]  r_keep_lim;

    logic [ROW_W-1:0] r_mem [QUERIES];
    logic [ROW_W-1:0] r_rd_row;
    logic             r_rd_valid;
    logic [QUERIES-1:0] r_qvalid;

    logic [QW-1:0] w_q_in;
    logic          w_acc;
    logic          w_free;
    t_cell_ctl     w_ctl;
    logic          w_emit;
    t_result       w_res;
    logic          w_wb;
    logic          w_clear;
    logic          w_inc;
    logic          w_dec;
    logic          w_set_disp;
    logic [CW-1:0] w_cap;
    logic          w_full;
    logic          w_beats;
    logic          w_low;
    logic [IW-1:0] w_last_idx;
    logic signed [17:0] w_ev_full;
    t_entry        w_new;
    t_entry        w_entry [KEEP];
    logic          w_flag  [KEEP];
    logic [KEEP*ENTRY_W-1:0] w_row_cells;

    assign w_acc  = i_hit.valid && i_hit.ready;
    assign w_free = !r_ovalid || o_res.ready;
    assign w_q_in = QMOD_TBL[i_hit.query_index*QW +: QW];
    assign i_hit.ready = (r_state == S_IDLE);

    // configuration port
    assign pready    = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_raw  <= '0;
            r_max_ev   <= '0;
            r_db       <= '0;
            r_keep_lim <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_MIN_RAW:  r_min_raw  <= pwdata[15:0];
                REG_MAX_EV:   r_max_ev   <= $signed(pwdata[15:0]);
                REG_DB_SIZE:  r_db       <= pwdata[13:0];
                REG_KEEP_LIM: r_keep_lim <= pwdata[4:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_MIN_RAW:  prdata = {16'd0, r_min_raw};
            REG_MAX_EV:   prdata = {16'd0, r_max_ev};
            REG_DB_SIZE:  prdata = {18'd0, r_db};
            REG_KEEP_LIM: prdata = {27'd0, r_keep_lim};
        endcase
    end

    // log2 E-value at full precision
    assign w_ev_full = $signed({4'd0, r_db}) + $signed({5'd0, r_item.query_len_log2})
                     - $signed({2'd0, r_item.bit_score});

    assign w_new = '{tag: r_item.hit_tag, score: r_item.raw_score, evalue: r_ev};

    // list capacity and ranking outcome
    assign w_cap = ((r_keep_lim == 5'd0) || (32'(r_keep_lim) > KEEP)) ? CW'(KEEP)
                                                                     : CW'(r_keep_lim);
    assign w_full     = (r_n >= w_cap);
    assign w_last_idx = IW'(r_n - CW'(1));
    assign w_beats    = (r_n != '0) && w_flag[w_last_idx];
    assign w_low      = (r_item.raw_score < r_min_raw);

    // cell chain
    for (genvar g = 0; g < KEEP; g++) begin : g_cell
        efk_cell #(.IDX(g), .CW(CW)) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_n         (r_n),
            .i_new       (w_new),
            .i_load      (r_rd_row[g*ENTRY_W +: ENTRY_W]),
            .i_prev      ((g == 0) ? w_new : w_entry[(g == 0) ? 0 : g-1]),
            .i_prev_flag ((g == 0) ? 1'b0 : w_flag[(g == 0) ? 0 : g-1]),
            .i_next      ((g == KEEP-1) ? t_entry'('0) : w_entry[(g == KEEP-1) ? g : g+1]),
            .o_entry     (w_entry[g]),
            .o_flag      (w_flag[g])
        );
        assign w_row_cells[g*ENTRY_W +: ENTRY_W] = w_entry[g];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_acc) n_state = S_LOAD;
            S_LOAD:   n_state = (r_item.kind == KIND_DRAIN) ? S_DRAIN : S_DECIDE;
            S_DECIDE: begin
                if (w_free) begin
                    if (w_low || r_ev_high || (w_full && !w_beats)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_WB;
                    end
                end
            end
            S_WB:     n_state = r_disp_pend ? S_DISP : S_IDLE;
            S_DISP:   if (w_free) n_state = S_IDLE;
            S_DRAIN:  if (w_free && (r_n <= CW'(1))) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs of each state
    always_comb begin
        w_ctl      = '0;
        w_emit     = 1'b0;
        w_wb       = 1'b0;
        w_clear    = 1'b0;
        w_inc      = 1'b0;
        w_dec      = 1'b0;
        w_set_disp = 1'b0;
        w_res      = '{out_query: r_item.query_index, out_tag: r_item.hit_tag,
                       out_score: r_item.raw_score, out_evalue_log2: r_ev,
                       status: STAT_KEPT, entry_valid: 1'b1, last: 1'b1};
        unique case (r_state)
            S_IDLE: ;
            S_LOAD: w_ctl.load = 1'b1;
            S_DECIDE: begin
                if (w_free) begin
                    w_emit = 1'b1;
                    priority if (w_low) begin
                        w_res.status = STAT_LOW;
                    end else if (r_ev_high) begin
                        w_res.status = STAT_HIGH;
                    end else if (!w_full) begin
                        w_ctl.insert = 1'b1;
                        w_inc        = 1'b1;
                    end else if (!w_beats) begin
                        w_res.status = STAT_RANKED;
                    end else begin
                        w_ctl.insert = 1'b1;
                        w_set_disp   = 1'b1;
                        w_res.last   = 1'b0;
                    end
                end
            end
            S_WB: w_wb = 1'b1;
            S_DISP: begin
                w_emit = w_free;
                w_res.out_tag         = r_disp.tag;
                w_res.out_score       = r_disp.score;
                w_res.out_evalue_log2 = r_disp.evalue;
                w_res.status          = STAT_RANKED;
            end
            S_DRAIN: begin
                w_res.status = STAT_DRAINED;
                if (w_free) begin
                    w_emit = 1'b1;
                    if (r_n == '0) begin
                        w_res.out_tag         = '0;
                        w_res.out_score       = '0;
                        w_res.out_evalue_log2 = '0;
                        w_res.entry_valid     = 1'b0;
                        w_clear               = 1'b1;
                    end else begin
                        w_res.out_tag         = w_entry[0].tag;
                        w_res.out_score       = w_entry[0].score;
                        w_res.out_evalue_log2 = w_entry[0].evalue;
                        w_res.last            = (r_n == CW'(1));
                        w_ctl.shift           = 1'b1;
                        w_dec                 = 1'b1;
                        w_clear               = (r_n == CW'(1));
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_qvalid <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_wb) begin
                r_qvalid[r_q] <= 1'b1;
            end else if (w_clear) begin
                r_qvalid[r_q] <= 1'b0;
            end
        end
    end

    // item, count and result payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= '{kind: i_hit.kind, query_index: i_hit.query_index,
                        hit_tag: i_hit.hit_tag, raw_score: i_hit.raw_score,
                        bit_score: i_hit.bit_score, query_len_log2: i_hit.query_len_log2};
            r_q    <= w_q_in;
        end
        if (r_state == S_LOAD) begin
            r_n       <= r_rd_valid ? r_rd_row[ROW_W-1 -: CW] : '0;
            r_ev_high <= (w_ev_full > 18'(r_max_ev));
            r_ev      <= (w_ev_full < -18'sd32768) ? 16'sh8000 : w_ev_full[15:0];
        end else if (w_inc) begin
            r_n <= r_n + CW'(1);
        end else if (w_dec) begin
            r_n <= r_n - CW'(1);
        end
        if (w_set_disp) begin
            r_disp <= w_entry[w_last_idx];
        end
        if (r_state == S_DECIDE) begin
            r_disp_pend <= w_set_disp;
        end
        if (w_emit) begin
            r_res <= w_res;
        end
    end

    // list row memory
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd_row   <= r_mem[w_q_in];
            r_rd_valid <= r_qvalid[w_q_in];
        end
        if (w_wb) begin
            r_mem[r_q] <= {r_n, w_row_cells};
        end
    end

    // drive result channel
    assign o_res.valid           = r_ovalid;
    assign o_res.out_query       = r_res.out_query;
    assign o_res.out_tag         = r_res.out_tag;
    assign o_res.out_score       = r_res.out_score;
    assign o_res.out_evalue_log2 = r_res.out_evalue_log2;
    assign o_res.status          = r_res.status;
    assign o_res.entry_valid     = r_res.entry_valid;
    assign o_res.last            = r_res.last;

endmodule

`default_nettype wire

@@ hw/rtl/efk_checker.sv @@
// Port-level checks for the per-query top-k screen, bound to its top level.
// Uses efk_pkg and the assertion macro header.
`default_nettype none
`include "evalue_filter_top_k_per_query_defines.svh"

module efk_checker
    import efk_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_tag,
    input wire logic [15:0] i_out_score,
    input wire logic [2:0]  i_status,
    input wire logic        i_entry_valid,
    input wire logic        i_last
);

    // hold a stalled result
    `EFK_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_tag) && $stable(i_status) && $stable(i_last), "stalled result changed")

    // take one item at a time
    `EFK_ASSERT_NEXT(a_one_item, i_in_valid && i_in_ready, !i_in_ready, "item accepted while busy")

    // empty drain is a single zeroed result
    `EFK_ASSERT(a_empty_drain, i_out_valid && !i_entry_valid |-> i_status == STAT_DRAINED && i_last && i_out_tag == 32'd0 && i_out_score == 16'd0, "bad empty drain result")

    // every status but drained reports a real entry
    `EFK_ASSERT(a_real_entry, i_out_valid && i_status != STAT_DRAINED |-> i_entry_valid, "screen result without entry")

endmodule

bind evalue_filter_top_k_per_query efk_checker u_efk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_hit.valid),
    .i_in_ready    (i_hit.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_tag     (o_res.out_tag),
    .i_out_score   (o_res.out_score),
    .i_status      (o_res.status),
    .i_entry_valid (o_res.entry_valid),
    .i_last        (o_res.last)
);

`default_nettype wire
